// File: rtl/core/rtf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rtf_pkg;

   // request operation codes
   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_RENDER = 1'b1;

   // configuration register indexes
   localparam int unsigned CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_COS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_SIN = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_U = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_V = 2'd3;

   // register and field widths
   localparam int unsigned STEP_W   = 19;
   localparam int unsigned ORIGIN_W = 23;
   localparam int unsigned CSR_W    = 23;
   localparam int unsigned FRAC_W   = 16;
   localparam int unsigned INDEX_W  = 14;
   localparam int unsigned TEXEL_W  = 8;
   localparam int unsigned POS_W    = 8;

   localparam logic [STEP_W-1:0] STEP_COS_RESET = 19'd65536;

   typedef struct packed {
      logic               operation;
      logic [INDEX_W-1:0] texel_index;
      logic [TEXEL_W-1:0] texel_value;
   } req_type;

   typedef struct packed {
      logic [TEXEL_W-1:0] pixel_value;
      logic [POS_W-1:0]   pixel_x;
      logic [POS_W-1:0]   pixel_y;
      logic               frame_last;
   } rsp_type;

endpackage

`default_nettype wire

// File: rtl/core/rotozoom_texel_fetch_core.sv
// Rotating, zooming texture mapper.
// Request channel (req_valid / req_stall / req_data): operation OP_WRITE stores
// texel_value at texel_index of the tiling texture; OP_RENDER produces the next
// screen pixel in raster order. Each render request gives one response on the
// rsp channel (rsp_valid / rsp_stall / rsp_data); writes give none.
// Throughput: one request per cycle while req_stall is low, with texel writes
// and renders mixed freely. A render response is registered in the texture
// memory read register and then in the output register.
// The texture memory has one write port and one registered read port; the
// walk coordinates are stepped in the same cycle the request is taken.
// When the receiver stalls, one result waits in the output register and one
// more in the read stage; requests keep being taken until both are full.
// A configuration write re-derives the frame start coordinates through a
// three-stage multiply path; req_stall is held while it settles. Reset likewise
// holds req_stall while the path settles and returns counters, coordinates and
// registers to their defaults. The texture is undefined until written.
`timescale 1ns / 1ps
`default_nettype none

module rotozoom_texel_fetch_core #(
   parameter int unsigned TEXTURE_SIZE = 128,
   parameter int unsigned SCREEN_SIZE  = 240,
   parameter int unsigned CENTER       = 120
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire rtf_pkg::req_type                  req_data,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output rtf_pkg::rsp_type                       rsp_data,
   input  wire logic                              csr_we,
   input  wire logic [rtf_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [rtf_pkg::CSR_W-1:0]         csr_wdata
);
   import rtf_pkg::*;

   localparam int unsigned TEX_W   = $clog2(TEXTURE_SIZE);
   localparam int unsigned COORD_W = TEX_W + FRAC_W;
   localparam int unsigned ADDR_W  = 2 * TEX_W;
   localparam int unsigned DEPTH   = TEXTURE_SIZE * TEXTURE_SIZE;
   localparam int unsigned CNT_W   = $clog2(SCREEN_SIZE);
   localparam logic [CNT_W-1:0]   LAST_POS = CNT_W'(SCREEN_SIZE - 1);
   localparam logic [COORD_W-1:0] CENTER_C = COORD_W'(CENTER);
   localparam logic [1:0]         SETTLE   = 2'd3;

   // configuration registers
   logic signed [STEP_W-1:0] step_cos_ff, step_sin_ff;
   logic [ORIGIN_W-1:0]      origin_u_ff, origin_v_ff;
   logic [1:0]               settle_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_cos_ff <= STEP_COS_RESET;
         step_sin_ff <= '0;
         origin_u_ff <= '0;
         origin_v_ff <= '0;
         settle_ff   <= SETTLE;
      end else begin
         if (csr_we) begin
            settle_ff <= SETTLE;
            unique case (csr_index)
               CSR_STEP_COS: step_cos_ff <= csr_wdata[STEP_W-1:0];
               CSR_STEP_SIN: step_sin_ff <= csr_wdata[STEP_W-1:0];
               CSR_ORIGIN_U: origin_u_ff <= csr_wdata[ORIGIN_W-1:0];
               CSR_ORIGIN_V: origin_v_ff <= csr_wdata[ORIGIN_W-1:0];
               default: ;
            endcase
         end else if (settle_ff != 2'd0) begin
            settle_ff <= settle_ff - 2'd1;
         end
      end
   end

   // steps widened to the coordinate range (mod texture size)
   logic [COORD_W-1:0] cos_w, sin_w;
   assign cos_w = COORD_W'(step_cos_ff);
   assign sin_w = COORD_W'(step_sin_ff);

   // frame start: origin minus center times the rotation steps
   logic [COORD_W-1:0] sum_ff, diff_ff, prod_sum_ff, prod_diff_ff;
   logic [COORD_W-1:0] start_u_ff, start_v_ff;

   always_ff @(posedge clock) begin
      sum_ff       <= cos_w + sin_w;
      diff_ff      <= sin_w - cos_w;
      prod_sum_ff  <= sum_ff * CENTER_C;
      prod_diff_ff <= diff_ff * CENTER_C;
      start_u_ff   <= COORD_W'(origin_u_ff) - prod_sum_ff;
      start_v_ff   <= COORD_W'(origin_v_ff) + prod_diff_ff;
   end

   // output register and read stage handshake
   logic    p1_valid_ff, out_valid_ff;
   logic    out_take, p1_move, req_take;
   logic    p1_last_ff;
   logic [POS_W-1:0] p1_x_ff, p1_y_ff;
   logic [TEXEL_W-1:0] rdata_ff;
   rsp_type out_ff;

   assign out_take  = out_valid_ff & ~rsp_stall;
   assign p1_move   = p1_valid_ff & (~out_valid_ff | out_take);
   assign req_stall = (settle_ff != 2'd0) | (p1_valid_ff & ~p1_move);
   assign req_take  = req_valid & ~req_stall;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   logic render_take, write_take;
   assign render_take = req_take & (req_data.operation == OP_RENDER);
   assign write_take  = req_take & (req_data.operation == OP_WRITE);

   // walk state
   logic [COORD_W-1:0] row_u_ff, row_v_ff, walk_u_ff, walk_v_ff;
   logic [CNT_W-1:0]   col_ff, row_ff;
   logic               frame_first, row_end, frame_end;
   logic [COORD_W-1:0] cur_u, cur_v, cur_row_u, cur_row_v;
   logic [COORD_W-1:0] row_u_in, row_v_in, walk_u_in, walk_v_in;
   logic [CNT_W-1:0]   col_in, row_in;
   logic [ADDR_W-1:0]  raddr, waddr;

   always_comb begin
      frame_first = (col_ff == '0) && (row_ff == '0);
      row_end     = (col_ff == LAST_POS);
      frame_end   = row_end && (row_ff == LAST_POS);
      cur_u     = frame_first ? start_u_ff : walk_u_ff;
      cur_v     = frame_first ? start_v_ff : walk_v_ff;
      cur_row_u = frame_first ? start_u_ff : row_u_ff;
      cur_row_v = frame_first ? start_v_ff : row_v_ff;
      raddr     = {cur_v[COORD_W-1 -: TEX_W], cur_u[COORD_W-1 -: TEX_W]};
      waddr     = ADDR_W'(req_data.texel_index);
      if (row_end) begin
         row_u_in  = cur_row_u + sin_w;
         row_v_in  = cur_row_v + cos_w;
         walk_u_in = row_u_in;
         walk_v_in = row_v_in;
         col_in    = '0;
         row_in    = (row_ff == LAST_POS) ? '0 : row_ff + 1'b1;
      end else begin
         row_u_in  = cur_row_u;
         row_v_in  = cur_row_v;
         walk_u_in = cur_u + cos_w;
         walk_v_in = cur_v - sin_w;
         col_in    = col_ff + 1'b1;
         row_in    = row_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_u_ff  <= '0;
         row_v_ff  <= '0;
         walk_u_ff <= '0;
         walk_v_ff <= '0;
         col_ff    <= '0;
         row_ff    <= '0;
      end else if (render_take) begin
         row_u_ff  <= row_u_in;
         row_v_ff  <= row_v_in;
         walk_u_ff <= walk_u_in;
         walk_v_ff <= walk_v_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
      end
   end

   // texture memory: one write port, one registered read port
   logic [TEXEL_W-1:0] tex_mem [DEPTH];

   always_ff @(posedge clock) begin
      if (write_take) begin
         tex_mem[waddr] <= req_data.texel_value;
      end
      if (render_take) begin
         rdata_ff <= tex_mem[raddr];
      end
   end

   // read stage
   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else if (render_take) begin
         p1_valid_ff <= 1'b1;
      end else if (p1_move) begin
         p1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (render_take) begin
         p1_x_ff    <= POS_W'(col_ff);
         p1_y_ff    <= POS_W'(row_ff);
         p1_last_ff <= frame_end;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (p1_move) begin
         out_valid_ff <= 1'b1;
      end else if (out_take) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (p1_move) begin
         out_ff.pixel_value <= rdata_ff;
         out_ff.pixel_x     <= p1_x_ff;
         out_ff.pixel_y     <= p1_y_ff;
         out_ff.frame_last  <= p1_last_ff;
      end
   end

endmodule

`default_nettype wire
